### hdl/pec_pkg.sv
// Shared types and constants for the prefix expression calculator.
`default_nettype none
package pec_pkg;
  localparam int unsigned StackDepth = 32;
  localparam int unsigned LevelW = $clog2(StackDepth + 1);
  localparam int unsigned AddrW = $clog2(StackDepth);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_UNKNOWN  = 3'd1,
    ST_ILLEGAL  = 3'd2,
    ST_DIVZERO  = 3'd3,
    ST_RANGE    = 3'd4,
    ST_OVERFLOW = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_SIGN = 2'd1,
    MODE_NUM  = 2'd2
  } scan_e;

  typedef enum logic [3:0] {
    S_IDLE,     // ready for a byte
    S_ACT,      // act on a latched byte
    S_OPER,     // push an operator
    S_NUM,      // check and feed a literal
    S_RD,       // issue stack read
    S_RDW,      // stack data back
    S_APPLY,    // combine with top operand
    S_DIV,      // divider iterating
    S_DIVEND,   // sign fix of quotient
    S_EOL,      // finish the line
    S_OUT       // result waiting
  } state_e;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTilde = 8'h7E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [31:0] MagSat = 32'h8000_0001;
endpackage
`default_nettype wire

### hdl/prefix_expression_calculator_top.sv
// Prefix expression calculator: byte scanner, operator stack and iterative evaluator.
// Each stack reduction that a byte triggers runs through the stack read, read-back and apply
// states; a division reduction iterates the divider instead (one quotient bit a cycle).
// One request is worked at a time; s_axis_tready is low while an item is in progress.
// A result sits in the output register until taken. Reset (rst_ni low) clears all line
// state; the operator stack memory is not cleared.
`default_nettype none
module prefix_expression_calculator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  wire logic        s_axis_tlast,   // end_of_line
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata    // [2:0] status, [34:3] value, rest zero
);
  import pec_pkg::*;

  state_e state_q, state_d;
  logic [7:0] ch_q;
  logic eol_q;
  scan_e mode_q;
  logic sign_q;
  logic [31:0] acc_q;
  logic lex_q, seen_q, done_q;
  logic [2:0] err_q;
  logic [31:0] fin_q, v_q;
  logic [LevelW-1:0] lvl_q;
  op_e pop_q;            // operator to push
  logic after_q;         // byte still needs idle-mode handling
  logic [34:0] stk [StackDepth];
  logic [34:0] rd_q;
  logic [31:0] rem_q, quo_q, dvs_q;
  logic [5:0] cnt_q;
  logic qneg_q;
  logic [2:0] ost_q;
  logic [31:0] oval_q;

  logic is_dig, is_blank, is_op;
  assign is_dig = (ch_q >= ChZero) && (ch_q <= ChNine);
  assign is_blank = (ch_q <= ChSpace) || ch_q[7];
  assign is_op = (ch_q == ChPlus) || (ch_q == ChMinus) || (ch_q == ChStar) ||
                 (ch_q == ChSlash);

  logic [AddrW-1:0] top_a;
  assign top_a = AddrW'(lvl_q - LevelW'(1));

  assign m_axis_tdata = {5'd0, oval_q, ost_q};

  logic [35:0] mul_w;
  assign mul_w = {4'd0, acc_q} * 36'd10 + {28'd0, ch_q - ChZero};
  logic [32:0] trial;
  assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

  logic [31:0] lim_w;
  assign lim_w = sign_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  logic num_feed;
  assign num_feed = (err_q == ST_OK) && !done_q && (acc_q <= lim_w);
  // where to go once the current token is finished
  state_e ret_st;
  assign ret_st = after_q ? S_ACT : (eol_q ? S_EOL : S_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_ACT;
      S_ACT: begin
        if (eol_q) begin
          if (!lex_q && mode_q == MODE_SIGN) state_d = S_OPER;
          else if (!lex_q && mode_q == MODE_NUM) state_d = S_NUM;
          else state_d = S_EOL;
        end else if (lex_q) state_d = S_IDLE;
        else if (mode_q == MODE_SIGN) state_d = is_dig ? S_IDLE : S_OPER;
        else if (mode_q == MODE_NUM) begin
          if (is_dig) state_d = S_IDLE;
          else if (is_blank || is_op) state_d = S_NUM;
          else state_d = S_IDLE;
        end else if (ch_q == ChStar || ch_q == ChSlash) state_d = S_OPER;
        else state_d = S_IDLE;
      end
      S_OPER:   state_d = ret_st;
      S_NUM:    state_d = num_feed ? S_RD : ret_st;
      S_RD:     state_d = (lvl_q == '0) ? ret_st : S_RDW;
      S_RDW: begin
        if (!rd_q[32]) state_d = ret_st;
        else if (rd_q[34:33] == OP_DIV && v_q == 32'd0) state_d = ret_st;
        else if (rd_q[34:33] == OP_DIV) state_d = S_DIV;
        else state_d = S_APPLY;
      end
      S_APPLY:  state_d = S_RD;
      S_DIV:    if (cnt_q == 6'd1) state_d = S_DIVEND;
      S_DIVEND: state_d = S_RD;
      S_EOL:    state_d = (!lex_q && !seen_q) ? S_IDLE : S_OUT;
      S_OUT:    if (m_axis_tready) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == S_IDLE);
    m_axis_tvalid = (state_q == S_OUT);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OPER && err_q == ST_OK && !done_q && lvl_q < LevelW'(StackDepth))
      stk[lvl_q[AddrW-1:0]] <= {pop_q, 1'b0, 32'd0};
    else if (state_q == S_RDW && !rd_q[32])
      stk[top_a] <= {rd_q[34:33], 1'b1, v_q};
    if (state_q == S_RD) rd_q <= stk[top_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= MODE_IDLE; sign_q <= 1'b0; acc_q <= '0; lex_q <= 1'b0;
      seen_q <= 1'b0; done_q <= 1'b0; err_q <= ST_OK; fin_q <= '0; lvl_q <= '0;
      ch_q <= '0; eol_q <= 1'b0; v_q <= '0; pop_q <= OP_ADD; after_q <= 1'b0;
      rem_q <= '0; quo_q <= '0; dvs_q <= '0; cnt_q <= '0; qneg_q <= 1'b0;
      ost_q <= '0; oval_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            ch_q <= s_axis_tdata; eol_q <= s_axis_tlast;
          end
        end
        S_ACT: begin
          after_q <= 1'b0;
          if (eol_q) begin
            if (!lex_q && mode_q == MODE_SIGN) pop_q <= sign_q ? OP_SUB : OP_ADD;
          end else if (lex_q) ;
          else if (mode_q == MODE_SIGN && is_dig) begin
            mode_q <= MODE_NUM; acc_q <= {24'd0, ch_q - ChZero};
          end else if (mode_q == MODE_SIGN) begin
            pop_q <= sign_q ? OP_SUB : OP_ADD; mode_q <= MODE_IDLE; sign_q <= 1'b0;
            after_q <= 1'b1;
          end else if (mode_q == MODE_NUM) begin
            if (is_dig) acc_q <= (mul_w > 36'h0_8000_0000) ? MagSat : mul_w[31:0];
            else if (is_blank) ;
            else if (is_op) after_q <= 1'b1;
            else lex_q <= 1'b1;
          end else begin
            if (is_blank) ;
            else if (is_dig) begin
              mode_q <= MODE_NUM; sign_q <= 1'b0; acc_q <= {24'd0, ch_q - ChZero};
            end else if (ch_q == ChPlus || ch_q == ChMinus) begin
              mode_q <= MODE_SIGN; sign_q <= (ch_q == ChMinus);
            end else if (ch_q == ChStar) pop_q <= OP_MUL;
            else if (ch_q == ChSlash) pop_q <= OP_DIV;
            else lex_q <= 1'b1;
          end
        end
        S_OPER: begin
          seen_q <= 1'b1;
          if (err_q == ST_OK) begin
            if (done_q) err_q <= ST_ILLEGAL;
            else if (lvl_q >= LevelW'(StackDepth)) err_q <= ST_OVERFLOW;
            else lvl_q <= lvl_q + LevelW'(1);
          end
        end
        S_NUM: begin
          seen_q <= 1'b1; acc_q <= '0; sign_q <= 1'b0; mode_q <= MODE_IDLE;
          if (err_q == ST_OK) begin
            if (done_q) err_q <= ST_ILLEGAL;
            else if (acc_q > lim_w) err_q <= ST_RANGE;
            else v_q <= sign_q ? 32'd0 - acc_q : acc_q;
          end
        end
        S_RD: begin
          if (lvl_q == '0) begin
            fin_q <= v_q; done_q <= 1'b1;
          end
        end
        S_RDW: begin
          if (!rd_q[32]) ;
          else if (rd_q[34:33] == OP_DIV && v_q == 32'd0) err_q <= ST_DIVZERO;
          else if (rd_q[34:33] == OP_DIV) begin
            qneg_q <= rd_q[31] ^ v_q[31];
            quo_q <= rd_q[31] ? 32'd0 - rd_q[31:0] : rd_q[31:0];
            dvs_q <= v_q[31] ? 32'd0 - v_q : v_q;
            rem_q <= '0; cnt_q <= 6'd32;
          end
        end
        S_APPLY: begin
          case (rd_q[34:33])
            OP_ADD:  v_q <= rd_q[31:0] + v_q;
            OP_SUB:  v_q <= rd_q[31:0] - v_q;
            default: v_q <= 32'(rd_q[31:0] * v_q);
          endcase
          lvl_q <= lvl_q - LevelW'(1);
        end
        S_DIV: begin
          if (!trial[32]) begin rem_q <= trial[31:0]; quo_q <= {quo_q[30:0], 1'b1}; end
          else begin rem_q <= {rem_q[30:0], quo_q[31]}; quo_q <= {quo_q[30:0], 1'b0}; end
          cnt_q <= cnt_q - 6'd1;
        end
        S_DIVEND: begin
          v_q <= qneg_q ? 32'd0 - quo_q : quo_q;
          lvl_q <= lvl_q - LevelW'(1);
        end
        S_EOL: begin
          if (lex_q || seen_q) begin
            oval_q <= '0;
            if (lex_q) ost_q <= ST_UNKNOWN;
            else if (err_q != ST_OK) ost_q <= err_q;
            else if (!done_q) ost_q <= ST_ILLEGAL;
            else begin ost_q <= ST_OK; oval_q <= fin_q; end
          end
          mode_q <= MODE_IDLE; sign_q <= 1'b0; acc_q <= '0; lex_q <= 1'b0;
          err_q <= ST_OK; seen_q <= 1'b0; done_q <= 1'b0; fin_q <= '0; lvl_q <= '0;
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire
